// ----- hw/rtl/rtcc_pkg.sv -----
// ----------------------------------------------------------------------------
// rtcc_pkg: shared types and constants for the real-time clock
// Register map, status bit masks, calendar tables and the request and result
// structures passed between the clock modules.
// ----------------------------------------------------------------------------
package rtcc_pkg;

  // Request actions.
  localparam logic [2:0] ACT_TICK    = 3'd0;
  localparam logic [2:0] ACT_RD_WORD = 3'd1;
  localparam logic [2:0] ACT_RD_BYTE = 3'd2;
  localparam logic [2:0] ACT_WR_WORD = 3'd3;
  localparam logic [2:0] ACT_WR_BYTE = 3'd4;

  // Registers held in flip-flops; everything above them is general RAM.
  localparam int CLK_REGS = 14;

  localparam logic [3:0] R_SEC     = 4'd0;
  localparam logic [3:0] R_SEC_AL  = 4'd1;
  localparam logic [3:0] R_MIN     = 4'd2;
  localparam logic [3:0] R_MIN_AL  = 4'd3;
  localparam logic [3:0] R_HOUR    = 4'd4;
  localparam logic [3:0] R_HOUR_AL = 4'd5;
  localparam logic [3:0] R_WDAY    = 4'd6;
  localparam logic [3:0] R_DAY     = 4'd7;
  localparam logic [3:0] R_MON     = 4'd8;
  localparam logic [3:0] R_YEAR    = 4'd9;
  localparam logic [3:0] R_A       = 4'd10;
  localparam logic [3:0] R_B       = 4'd11;
  localparam logic [3:0] R_C       = 4'd12;
  localparam logic [3:0] R_D       = 4'd13;

  localparam logic [7:0] B_SET     = 8'h80;
  localparam logic [7:0] B_PIE     = 8'h40;
  localparam logic [7:0] B_EVT     = 8'h08;
  localparam logic [7:0] B_BIN     = 8'h04;
  localparam logic [7:0] C_IRQF    = 8'h80;
  localparam logic [7:0] C_PF      = 8'h40;
  localparam logic [7:0] C_AF      = 8'h20;
  localparam logic [7:0] C_UF      = 8'h10;
  localparam logic [7:0] C_IRQ_SRC = 8'h70;
  localparam logic [7:0] D_VRT     = 8'h80;

  localparam logic [9:0] MS_PER_SEC = 10'd1000;
  localparam logic [9:0] PCOUNT_MAX = 10'd1023;

  localparam logic [9:0] RATE_MS [0:15] = '{
    10'd0, 10'd8, 10'd8, 10'd8, 10'd8, 10'd8, 10'd8, 10'd8,
    10'd8, 10'd8, 10'd16, 10'd31, 10'd63, 10'd125, 10'd250, 10'd500
  };

  localparam logic [7:0] MONTH_DAYS_BIN [0:11] = '{
    8'd31, 8'd28, 8'd31, 8'd30, 8'd31, 8'd30,
    8'd31, 8'd31, 8'd30, 8'd31, 8'd30, 8'd31
  };

  localparam logic [7:0] MONTH_DAYS_BCD [0:11] = '{
    8'h31, 8'h28, 8'h31, 8'h30, 8'h31, 8'h30,
    8'h31, 8'h31, 8'h30, 8'h31, 8'h30, 8'h31
  };

  typedef struct packed {
    logic [2:0]  action;
    logic [5:0]  idx;
    logic        high;
    logic [15:0] write_data;
    logic [2:0]  tick_ms;
  } item_t;

  typedef struct packed {
    logic [8:0] read_data;
    logic       timer_irq;
    logic       event_pulse;
  } result_t;

  typedef struct packed {
    logic       en;
    logic [5:0] idx;
    logic [7:0] data;
  } ram_wr_t;

  // Increment with an 8-bit wrap, then a decimal adjust of the low digit.
  function automatic logic [7:0] step_up(input logic [7:0] v, input logic bcd);
    logic [7:0] s;
    s = v + 8'd1;
    if (bcd && (s[3:0] > 4'd9)) begin
      s = s + 8'd6;
    end
    return s;
  endfunction

  // Length of the given month in the current number format.
  function automatic logic [7:0] days_of(input logic [7:0] mon, input logic bcd);
    logic [7:0] hi;
    logic [7:0] m;
    hi = {4'b0, mon[7:4]};
    m  = bcd ? ((hi << 3) + (hi << 1) + {4'b0, mon[3:0]}) : mon;
    if ((m < 8'd1) || (m > 8'd12)) begin
      return bcd ? 8'h31 : 8'd31;
    end
    return bcd ? MONTH_DAYS_BCD[4'(m - 8'd1)] : MONTH_DAYS_BIN[4'(m - 8'd1)];
  endfunction

endpackage

// ----- hw/rtl/rtcc_if.sv -----
// ----------------------------------------------------------------------------
// rtcc_in_if, rtcc_out_if: request and result channels of the clock
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface rtcc_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [6:0]  offset;
  logic [15:0] write_data;
  logic [2:0]  tick_ms;

  modport source (output valid, action, offset, write_data, tick_ms, input ready);
  modport sink (input valid, action, offset, write_data, tick_ms, output ready);
endinterface

interface rtcc_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] read_data;
  logic       timer_irq;
  logic       event_pulse;

  modport source (output valid, read_data, timer_irq, event_pulse, input ready);
  modport sink (input valid, read_data, timer_irq, event_pulse, output ready);
endinterface

// ----- hw/rtl/rtcc_ram.sv -----
// ----------------------------------------------------------------------------
// rtcc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rtcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 50
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/rtcc_exec.sv -----
// ----------------------------------------------------------------------------
// rtcc_exec: clock registers and request execution
// Holds the time, alarm and control registers with the millisecond and
// periodic counters; carries out one tick or register access per fired cycle.
// ----------------------------------------------------------------------------
module rtcc_exec #(
  parameter int REGISTER_COUNT = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  rtcc_pkg::item_t  item,
  input  logic [7:0]       ram_byte,
  output rtcc_pkg::result_t res,
  output rtcc_pkg::ram_wr_t ram_wr
);
  import rtcc_pkg::*;

  logic [7:0]  clk_r   [CLK_REGS];
  logic [7:0]  clk_nxt [CLK_REGS];
  logic [9:0]  ms_r, ms_nxt;
  logic [9:0]  pc_r, pc_nxt;

  logic        bcd;
  logic [7:0]  lim60, lim24, lim12, lim99;
  logic [10:0] ms_sum;
  logic        sec_tick;
  logic [7:0]  sec_inc, min_inc, hour_inc, wday_inc, day_inc, mon_inc, year_inc;
  logic        sec_wrap, min_wrap, hour_wrap, day_wrap, mon_wrap, year_wrap;
  logic [7:0]  sec_n, min_n, hour_n, wday_n, day_n, mon_n, year_n;
  logic        alarm_hit;
  logic [10:0] pc_sum;
  logic [9:0]  pc_sat;
  logic [9:0]  rate;
  logic [7:0]  c_val;
  logic        irq, evt;

  logic        in_rng, is_clk, is_read, is_write;
  logic [7:0]  cur;
  logic [7:0]  new_byte;

  // Calendar ripple for one elapsed second.
  always_comb begin
    bcd   = (clk_r[R_B] & B_BIN) == 8'd0;
    lim60 = bcd ? 8'h60 : 8'd60;
    lim24 = bcd ? 8'h24 : 8'd24;
    lim12 = bcd ? 8'h12 : 8'd12;
    lim99 = bcd ? 8'h99 : 8'd99;

    sec_inc  = step_up(clk_r[R_SEC], bcd);
    sec_wrap = sec_inc >= lim60;
    sec_n    = sec_wrap ? 8'd0 : sec_inc;

    min_inc  = step_up(clk_r[R_MIN], bcd);
    min_wrap = sec_wrap && (min_inc >= lim60);
    min_n    = sec_wrap ? (min_wrap ? 8'd0 : min_inc) : clk_r[R_MIN];

    hour_inc  = step_up(clk_r[R_HOUR], bcd);
    hour_wrap = min_wrap && (hour_inc >= lim24);
    hour_n    = min_wrap ? (hour_wrap ? 8'd0 : hour_inc) : clk_r[R_HOUR];

    wday_inc = step_up(clk_r[R_WDAY], bcd);
    wday_n   = hour_wrap ? ((wday_inc > 8'd7) ? 8'd1 : wday_inc) : clk_r[R_WDAY];

    day_inc  = step_up(clk_r[R_DAY], bcd);
    day_wrap = hour_wrap && (day_inc > days_of(clk_r[R_MON], bcd));
    day_n    = hour_wrap ? (day_wrap ? 8'd1 : day_inc) : clk_r[R_DAY];

    mon_inc  = step_up(clk_r[R_MON], bcd);
    mon_wrap = day_wrap && (mon_inc > lim12);
    mon_n    = day_wrap ? (mon_wrap ? 8'd1 : mon_inc) : clk_r[R_MON];

    year_inc  = step_up(clk_r[R_YEAR], bcd);
    year_wrap = mon_wrap && (year_inc > lim99);
    year_n    = mon_wrap ? (year_wrap ? 8'd0 : year_inc) : clk_r[R_YEAR];

    alarm_hit = (clk_r[R_SEC_AL] == sec_n) && (clk_r[R_MIN_AL] == min_n) &&
                (clk_r[R_HOUR_AL] == hour_n);
  end

  // Register access decode.
  always_comb begin
    in_rng   = {1'b0, item.idx} < 7'(REGISTER_COUNT);
    is_clk   = item.idx < 6'(CLK_REGS);
    is_read  = (item.action == ACT_RD_WORD) || (item.action == ACT_RD_BYTE) ||
               (item.action == ACT_WR_BYTE);
    is_write = (item.action == ACT_WR_WORD) || (item.action == ACT_WR_BYTE);
    if (!in_rng) begin
      cur = 8'd0;
    end else if (is_clk) begin
      cur = clk_r[item.idx[3:0]];
    end else begin
      cur = ram_byte;
    end
    if (item.action == ACT_WR_WORD) begin
      new_byte = item.write_data[8:1];
    end else if (item.high) begin
      new_byte = {item.write_data[0], cur[6:0]};
    end else begin
      new_byte = {cur[7], item.write_data[7:1]};
    end
  end

  always_comb begin
    clk_nxt = clk_r;
    ms_nxt  = ms_r;
    pc_nxt  = pc_r;
    res     = '0;
    ram_wr  = '0;
    ms_sum  = {1'b0, ms_r} + {8'd0, item.tick_ms};
    sec_tick = ms_sum >= {1'b0, MS_PER_SEC};
    pc_sum  = {1'b0, pc_r} + {8'd0, item.tick_ms};
    pc_sat  = (pc_sum > {1'b0, PCOUNT_MAX}) ? PCOUNT_MAX : pc_sum[9:0];
    rate    = RATE_MS[clk_r[R_A][3:0]];
    c_val   = clk_r[R_C];
    irq     = 1'b0;
    evt     = 1'b0;

    if (fire) begin
      if (item.action == ACT_TICK) begin
        ms_nxt = sec_tick ? 10'(ms_sum - {1'b0, MS_PER_SEC}) : ms_sum[9:0];
        if (sec_tick) begin
          if ((clk_r[R_B] & B_SET) != 8'd0) begin
            c_val = c_val & ~C_UF;
          end else begin
            clk_nxt[R_SEC]  = sec_n;
            clk_nxt[R_MIN]  = min_n;
            clk_nxt[R_HOUR] = hour_n;
            clk_nxt[R_WDAY] = wday_n;
            clk_nxt[R_DAY]  = day_n;
            clk_nxt[R_MON]  = mon_n;
            clk_nxt[R_YEAR] = year_n;
            c_val = alarm_hit ? (c_val | C_AF) : (c_val & ~C_AF);
            c_val = c_val | C_UF;
            if ((clk_r[R_B] & c_val & C_IRQ_SRC) != 8'd0) begin
              c_val = c_val | C_IRQF;
              irq   = 1'b1;
            end else begin
              c_val = c_val & ~C_IRQF;
            end
          end
        end
        pc_nxt = pc_sat;
        if ((rate != 10'd0) && (pc_sat >= rate)) begin
          pc_nxt = pc_sat - rate;
          evt    = (clk_r[R_B] & B_EVT) != 8'd0;
          c_val  = c_val | C_PF;
          if ((clk_r[R_B] & B_PIE) != 8'd0) begin
            c_val = c_val | C_IRQF;
            irq   = 1'b1;
          end
        end
        clk_nxt[R_C]    = c_val;
        res.timer_irq   = irq;
        res.event_pulse = evt;
      end else if (in_rng) begin
        if (is_read) begin
          if (item.idx == {2'b0, R_C}) begin
            clk_nxt[R_C] = 8'd0;
          end else if (item.idx == {2'b0, R_D}) begin
            clk_nxt[R_D] = D_VRT;
          end
        end
        if (item.action == ACT_RD_WORD) begin
          res.read_data = {cur, 1'b0};
        end else if (item.action == ACT_RD_BYTE) begin
          res.read_data = item.high ? {8'd0, cur[7]} : {1'b0, cur[6:0], 1'b0};
        end
        if (is_write && (item.idx != {2'b0, R_C}) && (item.idx != {2'b0, R_D})) begin
          if (is_clk) begin
            clk_nxt[item.idx[3:0]] = new_byte;
          end else begin
            ram_wr.en   = 1'b1;
            ram_wr.idx  = item.idx;
            ram_wr.data = new_byte;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_r <= '{default: 8'd0};
      ms_r  <= '0;
      pc_r  <= '0;
    end else begin
      clk_r <= clk_nxt;
      ms_r  <= ms_nxt;
      pc_r  <= pc_nxt;
    end
  end

endmodule

// ----- hw/rtl/rtc_calendar_alarm_periodic.sv -----
// ----------------------------------------------------------------------------
// rtc_calendar_alarm_periodic: real-time clock with calendar, alarm and
// periodic interrupt
// Each request is a millisecond tick or a word or byte register access; every
// request returns one result. A request is taken on every cycle the output
// side keeps up. The edge that takes the request loads it into the stage
// register and launches the registered read of the general-purpose RAM;
// once the output register is free, the tick or access is executed against
// the clock registers into the output register. The RAM holds registers 14
// and up; a valid bit per entry makes unwritten entries read as zero right
// after reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module rtc_calendar_alarm_periodic #(
  parameter int REGISTER_COUNT = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  rtcc_in_if.sink          in_ch,
  rtcc_out_if.source       out_ch
);
  import rtcc_pkg::*;

  localparam int RAM_DEPTH = REGISTER_COUNT - CLK_REGS;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  logic              accept;
  logic              s1_fire;
  logic              s1_valid_r, s1_valid_nxt;
  item_t             s1_item_r;
  logic              out_valid_r, out_valid_nxt;
  result_t           out_res_r;
  result_t           res;
  ram_wr_t           ram_wr;
  logic [5:0]        in_idx;
  logic [5:0]        rd_off, wr_off, s1_off;
  logic [RAM_AW-1:0] ram_q;
  logic [7:0]        ram_rdata;
  logic [RAM_DEPTH-1:0] valid_r;
  logic              fwd_r;
  logic [7:0]        fwd_data_r;
  logic              s1_in_ram;
  logic [7:0]        ram_byte;

  assign in_idx  = in_ch.offset[6:1];
  assign s1_fire = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_fire;
  assign accept  = in_ch.valid && in_ch.ready;

  assign rd_off = in_idx - 6'(CLK_REGS);
  assign wr_off = ram_wr.idx - 6'(CLK_REGS);
  assign s1_off = s1_item_r.idx - 6'(CLK_REGS);
  assign ram_q  = s1_off[RAM_AW-1:0];

  rtcc_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_wr.en),
    .waddr (wr_off[RAM_AW-1:0]),
    .wdata (ram_wr.data),
    .re    (accept),
    .raddr (rd_off[RAM_AW-1:0]),
    .rdata (ram_rdata)
  );

  assign s1_in_ram = (s1_item_r.idx >= 6'(CLK_REGS)) &&
                     ({1'b0, s1_item_r.idx} < 7'(REGISTER_COUNT));

  always_comb begin
    ram_byte = 8'd0;
    if (s1_in_ram && valid_r[ram_q]) begin
      ram_byte = fwd_r ? fwd_data_r : ram_rdata;
    end
  end

  rtcc_exec #(
    .REGISTER_COUNT (REGISTER_COUNT)
  ) u_exec (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (s1_fire),
    .item     (s1_item_r),
    .ram_byte (ram_byte),
    .res      (res),
    .ram_wr   (ram_wr)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      fwd_r       <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_wr.en) begin
        valid_r[wr_off[RAM_AW-1:0]] <= 1'b1;
      end
      if (accept) begin
        fwd_r <= ram_wr.en && (ram_wr.idx == in_idx);
      end
    end
  end

  // The RAM read issued with a new request misses a write made in the same
  // cycle, so that byte is kept aside and used in place of the read data.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r.action     <= in_ch.action;
      s1_item_r.idx        <= in_idx;
      s1_item_r.high       <= in_ch.offset[0];
      s1_item_r.write_data <= in_ch.write_data;
      s1_item_r.tick_ms    <= in_ch.tick_ms;
      fwd_data_r           <= ram_wr.data;
    end
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_data   = out_res_r.read_data;
  assign out_ch.timer_irq   = out_res_r.timer_irq;
  assign out_ch.event_pulse = out_res_r.event_pulse;

endmodule
